FILE: design/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the design files.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

FILE: design/csol_pkg.sv
// -----------------------------------------------------------------------------
// csol_pkg
// Constants and types for the class set ordering lookup.
// -----------------------------------------------------------------------------
`default_nettype none

package csol_pkg;

	localparam int MAP_BITS    = 64;
	localparam int TABLE_DEPTH = 64;

	localparam int IN_W  = 64;
	localparam int CFG_W = 7;
	localparam int NUM_W = 7;
	localparam int ST_W  = 3;

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int BIT_W  = $clog2(MAP_BITS);

	typedef enum logic [ST_W-1:0] {
		ST_EMPTY  = 3'd0,
		ST_SINGLE = 3'd1,
		ST_FOUND  = 3'd2,
		ST_ADDED  = 3'd3,
		ST_FULL   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DECODE = 4'b0010,
		S_SEARCH = 4'b0100,
		S_EMIT   = 4'b1000
	} state_t;

endpackage

`default_nettype wire

FILE: design/csol_ram.sv
// -----------------------------------------------------------------------------
// csol_ram
// Generic single write port, single read port RAM with registered read.
// -----------------------------------------------------------------------------
`default_nettype none

module csol_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

FILE: design/class_set_ordering_lookup_core.sv
// -----------------------------------------------------------------------------
// class_set_ordering_lookup_core
// Maps a masked class bitmap to an ordering number: class index for a single
// class, or table slot plus class count for a stored multi-class set.
// -----------------------------------------------------------------------------
//  channel   signals                                  direction
//  cfg       cfg_valid cfg_ready class_count          in
//  in        in_valid in_ready class_map              in
//  out       out_valid out_ready ordering_number status  out
//
//  Empty or single-class request: result set in the decode state, then emitted.
//  Multi-class request: the search state compares stored slots in order, up to
//  entry count, one table read and compare per cycle, before the emit state.
//  in_ready is low from accept until the result is loaded into the output reg.
//  A result waiting on out_ready holds the block in its emit state.
//  Reset clears the entry count; the table needs no clearing pass.
// -----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module class_set_ordering_lookup_core (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [csol_pkg::CFG_W-1:0] class_count,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [csol_pkg::IN_W-1:0]  class_map,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [csol_pkg::NUM_W-1:0]    ordering_number,
	output logic [csol_pkg::ST_W-1:0]     status
);

	import csol_pkg::*;

	state_t               state_q, state_d;
	logic [CFG_W-1:0]     class_count_q;
	logic [CNT_W-1:0]     entry_count_q;
	logic [MAP_BITS-1:0]  map_q;
	logic [MAP_BITS-1:0]  mask_q;
	logic [NUM_W-1:0]     n_q;
	logic [IDX_W-1:0]     cidx_q;
	logic [NUM_W-1:0]     res_num_q;
	status_t              res_st_q;
	logic                 out_valid_q;
	logic [NUM_W-1:0]     out_num_q;
	status_t              out_st_q;

	logic [CFG_W-1:0]     eff_n;
	logic [MAP_BITS-1:0]  eff_mask;
	logic                 accept;
	logic                 is_single;
	logic [BIT_W-1:0]     single_idx;
	logic [MAP_BITS-1:0]  rd_data;
	logic [IDX_W-1:0]     rd_addr;
	logic                 hit;
	logic                 last_cmp;
	logic                 do_miss;
	logic                 wr_en;
	logic                 emit;
	logic                 res_load;
	logic [NUM_W-1:0]     res_num_d;
	status_t              res_st_d;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;

	assign eff_n    = (class_count_q > CFG_W'(MAP_BITS)) ? CFG_W'(MAP_BITS) : class_count_q;
	assign eff_mask = ~({MAP_BITS{1'b1}} << eff_n);

	assign is_single = ((map_q & (map_q - MAP_BITS'(1))) == '0);

	always_comb begin
		single_idx = '0;
		for (int i = 0; i < MAP_BITS; i++) begin
			if (map_q[i]) begin
				single_idx = single_idx | BIT_W'(i);
			end
		end
	end

	assign rd_addr  = (state_q == S_SEARCH) ? cidx_q + IDX_W'(1) : '0;
	assign hit      = (((rd_data ^ map_q) & mask_q) == '0);
	assign last_cmp = ((CNT_W'(cidx_q) + CNT_W'(1)) == entry_count_q);

	always_comb begin
		do_miss = 1'b0;
		if (state_q == S_DECODE) begin
			do_miss = (map_q != '0) && !is_single && (entry_count_q == '0);
		end else if (state_q == S_SEARCH) begin
			do_miss = !hit && last_cmp;
		end
	end

	assign wr_en = do_miss && (entry_count_q != CNT_W'(TABLE_DEPTH));

	always_comb begin
		state_d   = state_q;
		res_load  = 1'b0;
		res_num_d = '0;
		res_st_d  = ST_EMPTY;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (map_q == '0) begin
					res_load = 1'b1;
					res_st_d = ST_EMPTY;
					state_d  = S_EMIT;
				end else if (is_single) begin
					res_load  = 1'b1;
					res_st_d  = ST_SINGLE;
					res_num_d = NUM_W'(single_idx);
					state_d   = S_EMIT;
				end else if (do_miss) begin
					res_load = 1'b1;
					state_d  = S_EMIT;
					if (wr_en) begin
						res_st_d  = ST_ADDED;
						res_num_d = NUM_W'(entry_count_q) + n_q;
					end else begin
						res_st_d = ST_FULL;
					end
				end else begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (hit) begin
					res_load  = 1'b1;
					res_st_d  = ST_FOUND;
					res_num_d = NUM_W'(cidx_q) + n_q;
					state_d   = S_EMIT;
				end else if (do_miss) begin
					res_load = 1'b1;
					state_d  = S_EMIT;
					if (wr_en) begin
						res_st_d  = ST_ADDED;
						res_num_d = NUM_W'(entry_count_q) + n_q;
					end else begin
						res_st_d = ST_FULL;
					end
				end
			end
			S_EMIT: begin
				if (emit) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign emit = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			class_count_q <= CFG_W'(64);
			entry_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				class_count_q <= class_count;
			end
			if (wr_en) begin
				entry_count_q <= entry_count_q + CNT_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			map_q  <= class_map[MAP_BITS-1:0] & eff_mask;
			mask_q <= eff_mask;
			n_q    <= eff_n;
		end
		if (state_q == S_DECODE) begin
			cidx_q <= '0;
		end else if (state_q == S_SEARCH) begin
			cidx_q <= cidx_q + IDX_W'(1);
		end
		if (res_load) begin
			res_num_q <= res_num_d;
			res_st_q  <= res_st_d;
		end
		if (emit) begin
			out_num_q <= res_num_q;
			out_st_q  <= res_st_q;
		end
	end

	csol_ram #(
		.WIDTH(MAP_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(entry_count_q[IDX_W-1:0]),
		.wr_data(map_q),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign out_valid       = out_valid_q;
	assign ordering_number = out_num_q;
	assign status          = out_st_q;

	`ASSERT_NEVER(a_count_bound, clk, arst_n, entry_count_q > CNT_W'(TABLE_DEPTH), "entry count over depth")
	`ASSERT_AT(a_write_advances, clk, arst_n, wr_en |=> (entry_count_q == $past(entry_count_q) + CNT_W'(1)), "write did not advance count")
	`ASSERT_NEVER(a_search_range, clk, arst_n, (state_q == S_SEARCH) && (CNT_W'(cidx_q) >= entry_count_q), "search past last entry")
	`ASSERT_AT(a_emit_once, clk, arst_n, emit |=> (state_q == S_IDLE) && out_valid_q, "result not presented")

endmodule

`default_nettype wire

FILE: tb/class_set_ordering_lookup_checker.sv
// -----------------------------------------------------------------------------
// class_set_ordering_lookup_checker
// Watches the cfg, in and out channels of the class set ordering lookup,
// predicts the ordering number and status of every accepted request and
// compares each result, in order, against the oldest prediction.
// -----------------------------------------------------------------------------
module class_set_ordering_lookup_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [csol_pkg::CFG_W-1:0] class_count,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [csol_pkg::IN_W-1:0]  class_map,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [csol_pkg::NUM_W-1:0] ordering_number,
	input  logic [csol_pkg::ST_W-1:0]  status,
	output int                         mismatches,
	output int                         pending
);

	import csol_pkg::*;

	typedef struct packed {
		logic [NUM_W-1:0] number;
		status_t          code;
	} ordering_t;

	ordering_t        expected_orders[$];
	logic [CFG_W-1:0] classes_in_use;
	logic [IN_W-1:0]  stored_sets[TABLE_DEPTH];
	int               stored_count;

	function automatic ordering_t order_of(input logic [IN_W-1:0] raw);
		int              span;
		int              slot;
		int              s;
		int              b;
		logic [IN_W-1:0] keep;
		logic [IN_W-1:0] masked;
		ordering_t       r;
		span = (classes_in_use > MAP_BITS) ? MAP_BITS : int'(classes_in_use);
		keep = '1;
		if (span < IN_W)
			keep = ~({IN_W{1'b1}} << span);
		masked = raw & keep;
		r.number = '0;
		slot = -1;
		if (masked == '0) begin
			r.code = ST_EMPTY;
		end else if ((masked & (masked - 1'b1)) == '0) begin
			r.code = ST_SINGLE;
			for (b = 0; b < IN_W; b++)
				if (masked[b])
					r.number = NUM_W'(b);
		end else begin
			for (s = 0; s < stored_count; s++)
				if (slot < 0 && ((stored_sets[s] ^ masked) & keep) == '0)
					slot = s;
			if (slot >= 0) begin
				r.code = ST_FOUND;
				r.number = NUM_W'(slot + span);
			end else if (stored_count >= TABLE_DEPTH) begin
				r.code = ST_FULL;
			end else begin
				stored_sets[stored_count] = masked;
				r.number = NUM_W'(stored_count + span);
				r.code = ST_ADDED;
				stored_count++;
			end
		end
		return r;
	endfunction

	initial begin
		mismatches = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		ordering_t want;
		if (!arst_n) begin
			classes_in_use = 7'd64;
			stored_count = 0;
			expected_orders.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_orders.size() == 0) begin
					$display("%0t: unexpected result ordering_number %0d status %0d",
						$time, ordering_number, status);
					mismatches++;
				end else begin
					want = expected_orders.pop_front();
					if (ordering_number !== want.number) begin
						$display("%0t: ordering_number expected %0d, got %0d",
							$time, want.number, ordering_number);
						mismatches++;
					end
					if (status !== want.code) begin
						$display("%0t: status expected %0d, got %0d",
							$time, want.code, status);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				classes_in_use = class_count;
			if (in_valid && in_ready)
				expected_orders.push_back(order_of(class_map));
			pending = expected_orders.size();
		end
	end

endmodule

FILE: tb/class_set_ordering_lookup_core_tb.sv
// -----------------------------------------------------------------------------
// class_set_ordering_lookup_core_tb
// Drives class maps and class count writes into the lookup core with random
// gaps and output stalls: a directed pass over empty, single-class, stored,
// masked and saturated cases, then random phases that fill the set table and
// revisit stored sets under changing class counts.
// -----------------------------------------------------------------------------
module class_set_ordering_lookup_core_tb;
	import csol_pkg::*;

	localparam int IDLE_LIMIT  = 4000;
	localparam int PHASE_ITEMS = 125;
	localparam int PHASES      = 14;

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] class_count;
	logic             in_valid;
	logic             in_ready;
	logic [IN_W-1:0]  class_map;
	logic             out_valid;
	logic             out_ready;
	logic [NUM_W-1:0] ordering_number;
	logic [ST_W-1:0]  status;

	int               mismatches;
	int               pending;
	int               idle_cycles = 0;
	bit               in_paced = 1'b1;
	bit               out_paced = 1'b1;
	logic [IN_W-1:0]  seen_sets[$];
	logic [CFG_W-1:0] phase_counts[PHASES] = '{7'd64, 7'd33, 7'd3, 7'd127, 7'd8, 7'd0,
		7'd2, 7'd64, 7'd5, 7'd16, 7'd0, 7'd0, 7'd1, 7'd0};

	class_set_ordering_lookup_core i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.class_count     (class_count),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.class_map       (class_map),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.ordering_number (ordering_number),
		.status          (status)
	);

	class_set_ordering_lookup_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.class_count     (class_count),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.class_map       (class_map),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.ordering_number (ordering_number),
		.status          (status),
		.mismatches      (mismatches),
		.pending         (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("class_set_ordering_lookup_core_tb: errors");
			$finish;
		end
	end

	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = out_paced ? $urandom_range(0, 7) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	task automatic send_map(input logic [IN_W-1:0] m);
		int gap;
		gap = in_paced ? $urandom_range(0, 7) : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		class_map <= m;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	task automatic write_class_count(input logic [CFG_W-1:0] v);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		class_count <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [IN_W-1:0] next_map();
		logic [IN_W-1:0] m;
		case ($urandom_range(0, 9))
			0: m = '0;
			1: m = 64'h1 << $urandom_range(0, 63);
			2, 3, 4: begin
				if (seen_sets.size() != 0)
					m = seen_sets[$urandom_range(0, seen_sets.size() - 1)];
				else
					m = {$urandom, $urandom};
			end
			5: m = (64'h1 << $urandom_range(0, 63)) | (64'h1 << $urandom_range(0, 63));
			6: begin
				m = '0;
				m[7:0] = 8'($urandom);
			end
			default: m = {$urandom, $urandom};
		endcase
		if ((m & (m - 1'b1)) != '0) begin
			seen_sets.push_back(m);
			if (seen_sets.size() > 128)
				void'(seen_sets.pop_front());
		end
		return m;
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		class_count = '0;
		in_valid = 1'b0;
		class_map = '0;
		phase_counts[10] = CFG_W'($urandom_range(0, 127));
		phase_counts[11] = CFG_W'($urandom_range(0, 127));
		phase_counts[13] = CFG_W'($urandom_range(0, 127));
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		send_map(64'h0);
		send_map(64'h1);
		send_map(64'h8000_0000_0000_0000);
		send_map(64'hFFFF_FFFF_FFFF_FFFF);
		send_map(64'hFFFF_FFFF_FFFF_FFFF);
		send_map(64'h3);
		send_map(64'h8000_0000_0000_0001);
		send_map(64'h3);
		send_map(64'h0000_0001_0000_0000);
		write_class_count(7'd0);
		send_map(64'hFFFF_FFFF_FFFF_FFFF);
		send_map(64'h5);
		write_class_count(7'd127);
		send_map(64'hFFFF_FFFF_FFFF_FFFF);
		send_map(64'h5555_5555_5555_5555);
		write_class_count(7'd2);
		send_map(64'hFFFF_FFFF_FFFF_FFFF);
		send_map(64'h2);
		send_map(64'h4);
		write_class_count(7'd1);
		send_map(64'h3);
		send_map(64'h2);
		write_class_count(7'd65);
		send_map(64'h6);

		for (int p = 0; p < PHASES; p++) begin
			write_class_count(phase_counts[p]);
			in_paced = (p % 4 != 2);
			out_paced = (p % 3 != 1);
			repeat (PHASE_ITEMS) send_map(next_map());
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		if (mismatches == 0)
			$display("class_set_ordering_lookup_core_tb: clean");
		else
			$display("class_set_ordering_lookup_core_tb: errors");
		$finish;
	end

endmodule
